@@ sv/wavhv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavhv_pkg
// Tags, limits, register indexes and verdict codes for the WAV header
// validator.
// ----------------------------------------------------------------------------
package wavhv_pkg;

    localparam int unsigned CFG_WIDTH = 32;
    localparam int unsigned CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_SAMPLES       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPECTED_RATE     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPECTED_CHANNELS = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPECTED_BITS     = 2'd3;

    localparam logic [23:0] MAX_SAMPLES_RESET       = 24'd480000;
    localparam logic [31:0] EXPECTED_RATE_RESET     = 32'd16000;
    localparam logic [15:0] EXPECTED_CHANNELS_RESET = 16'd1;
    localparam logic [15:0] EXPECTED_BITS_RESET     = 16'd16;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [25:0] WAV_HEADER_BYTES = 26'd44;
    localparam logic [31:0] FMT_MIN_BYTES    = 32'd16;
    localparam logic [15:0] FORMAT_PCM       = 16'd1;

    localparam logic [3:0] PREAMBLE_TAG_LAST = 4'd3;
    localparam logic [3:0] PREAMBLE_LAST     = 4'd11;
    localparam logic [3:0] CHUNK_TAG_LAST    = 4'd3;
    localparam logic [3:0] CHUNK_HDR_LAST    = 4'd7;
    localparam logic [3:0] FMT_FIELDS_LAST   = 4'd15;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_EMPTY       = 2'd1,
        STATUS_TOO_LARGE   = 2'd2,
        STATUS_UNSUPPORTED = 2'd3
    } status_t;

endpackage

@@ sv/wav_header_validator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_validator
// Byte-stream RIFF/WAVE header checker giving one verdict per file.
// ----------------------------------------------------------------------------
// Takes one file byte per beat and sustains one beat per clock while the
// input is not stalled. Each byte is registered at the input, then compare
// and shift logic updates the parse state; the verdict for a file lands in
// the output register in the step that takes its end_of_file byte from the
// input register. The input stalls only while an end_of_file byte waits for
// a verdict still held in a stalled output register. The user must write the
// sample limit, rate, channel and bit-depth registers through the cfg port
// only while no file is in flight; the block itself does not enforce this.
module wav_header_validator
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_write,
    input  logic [wavhv_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [wavhv_pkg::CFG_WIDTH-1:0]         cfg_data,

    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [7:0]                              data_byte,
    input  logic                                    start_of_file,
    input  logic                                    end_of_file,
    input  logic [31:0]                             file_length,

    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    accepted,
    output logic [1:0]                              status
);

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_CHUNK,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    // configuration
    logic [23:0] max_samples_reg;
    logic [31:0] expected_rate_reg;
    logic [15:0] expected_channels_reg;
    logic [15:0] expected_bits_reg;

    // input stage
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_sof_reg;
    logic        s1_eof_reg;
    logic [31:0] s1_len_reg;

    // parse state
    phase_t      phase_reg,         phase_next;
    logic [31:0] pos_reg,           pos_next;
    logic [3:0]  hdr_count_reg,     hdr_count_next;
    logic [31:0] tag_shift_reg,     tag_shift_next;
    logic [31:0] chunk_len_reg,     chunk_len_next;
    logic [31:0] payload_left_reg,  payload_left_next;
    logic        pad_pending_reg,   pad_pending_next;
    logic [15:0] format_code_reg,   format_code_next;
    logic [15:0] channels_reg,      channels_next;
    logic [31:0] rate_seen_reg,     rate_seen_next;
    logic [15:0] sample_bits_reg,   sample_bits_next;
    logic        fmt_found_reg,     fmt_found_next;
    logic        data_found_reg,    data_found_next;
    logic [31:0] data_size_reg,     data_size_next;
    logic        fault_reg,         fault_next;

    // output stage
    logic        out_valid_reg;
    logic        accepted_reg,      accepted_next;
    wavhv_pkg::status_t status_reg, status_next;

    logic        proceed;
    logic        step;
    logic        is_fmt;
    logic [33:0] chunk_end;
    logic [25:0] size_limit;
    logic        mismatch;

    assign proceed  = !s1_eof_reg || !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && proceed;
    assign in_stall = s1_valid_reg && !proceed;

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign status    = status_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        hdr_count_next    = hdr_count_reg;
        tag_shift_next    = tag_shift_reg;
        chunk_len_next    = chunk_len_reg;
        payload_left_next = payload_left_reg;
        pad_pending_next  = pad_pending_reg;
        format_code_next  = format_code_reg;
        channels_next     = channels_reg;
        rate_seen_next    = rate_seen_reg;
        sample_bits_next  = sample_bits_reg;
        fmt_found_next    = fmt_found_reg;
        data_found_next   = data_found_reg;
        data_size_next    = data_size_reg;
        fault_next        = fault_reg;
        is_fmt            = 1'b0;
        chunk_end         = '0;
        size_limit        = '0;
        mismatch          = 1'b0;
        accepted_next     = 1'b0;
        status_next       = wavhv_pkg::STATUS_OK;

        // clear on start of file
        if (s1_sof_reg)
        begin
            phase_next        = PH_RIFF;
            pos_next          = '0;
            hdr_count_next    = '0;
            tag_shift_next    = '0;
            chunk_len_next    = '0;
            payload_left_next = '0;
            pad_pending_next  = 1'b0;
            format_code_next  = '0;
            channels_next     = '0;
            rate_seen_next    = '0;
            sample_bits_next  = '0;
            fmt_found_next    = 1'b0;
            data_found_next   = 1'b0;
            data_size_next    = '0;
            fault_next        = 1'b0;
        end

        if (pos_next < s1_len_reg)
        begin
            case (phase_next)
                PH_RIFF:
                begin
                    tag_shift_next = {s1_byte_reg, tag_shift_next[31:8]};
                    if ((hdr_count_next == wavhv_pkg::PREAMBLE_TAG_LAST
                            && tag_shift_next != wavhv_pkg::TAG_RIFF)
                        || (hdr_count_next == wavhv_pkg::PREAMBLE_LAST
                            && tag_shift_next != wavhv_pkg::TAG_WAVE))
                    begin
                        fault_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else if (hdr_count_next == wavhv_pkg::PREAMBLE_LAST)
                    begin
                        hdr_count_next = '0;
                        phase_next     = PH_CHUNK;
                    end
                    else
                    begin
                        hdr_count_next = hdr_count_next + 4'd1;
                    end
                end
                PH_CHUNK:
                begin
                    if (hdr_count_next == '0
                        && ({2'b0, pos_next} + 34'd8) > {2'b0, s1_len_reg})
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (hdr_count_next <= wavhv_pkg::CHUNK_TAG_LAST)
                            tag_shift_next = {s1_byte_reg, tag_shift_next[31:8]};
                        else
                            chunk_len_next = {s1_byte_reg, chunk_len_next[31:8]};
                        if (hdr_count_next < wavhv_pkg::CHUNK_HDR_LAST)
                        begin
                            hdr_count_next = hdr_count_next + 4'd1;
                        end
                        else
                        begin
                            hdr_count_next = '0;
                            is_fmt    = (tag_shift_next == wavhv_pkg::TAG_FMT);
                            chunk_end = {2'b0, pos_next} + {2'b0, chunk_len_next}
                                      + 34'd1 + {33'b0, chunk_len_next[0]};
                            if (chunk_end > {2'b0, s1_len_reg}
                                || (is_fmt && chunk_len_next < wavhv_pkg::FMT_MIN_BYTES))
                            begin
                                fault_next = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else if (is_fmt)
                            begin
                                phase_next = PH_FMT;
                            end
                            else
                            begin
                                if (tag_shift_next == wavhv_pkg::TAG_DATA)
                                begin
                                    data_found_next = 1'b1;
                                    data_size_next  = chunk_len_next;
                                end
                                payload_left_next = chunk_len_next;
                                pad_pending_next  = chunk_len_next[0];
                                phase_next = (payload_left_next == '0 && !pad_pending_next)
                                           ? PH_CHUNK : PH_SKIP;
                            end
                        end
                    end
                end
                PH_FMT:
                begin
                    case (hdr_count_next)
                        4'd0:    format_code_next = {8'b0, s1_byte_reg};
                        4'd1:    format_code_next[15:8] = s1_byte_reg;
                        4'd2:    channels_next = {8'b0, s1_byte_reg};
                        4'd3:    channels_next[15:8] = s1_byte_reg;
                        4'd4:    rate_seen_next = {24'b0, s1_byte_reg};
                        4'd5:    rate_seen_next[15:8] = s1_byte_reg;
                        4'd6:    rate_seen_next[23:16] = s1_byte_reg;
                        4'd7:    rate_seen_next[31:24] = s1_byte_reg;
                        4'd14:   sample_bits_next = {8'b0, s1_byte_reg};
                        4'd15:   sample_bits_next[15:8] = s1_byte_reg;
                        default: ;
                    endcase
                    if (hdr_count_next < wavhv_pkg::FMT_FIELDS_LAST)
                    begin
                        hdr_count_next = hdr_count_next + 4'd1;
                    end
                    else
                    begin
                        hdr_count_next    = '0;
                        fmt_found_next    = 1'b1;
                        payload_left_next = chunk_len_next - wavhv_pkg::FMT_MIN_BYTES;
                        pad_pending_next  = chunk_len_next[0];
                        phase_next = (payload_left_next == '0 && !pad_pending_next)
                                   ? PH_CHUNK : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (payload_left_next != '0)
                        payload_left_next = payload_left_next - 32'd1;
                    else
                        pad_pending_next = 1'b0;
                    phase_next = (payload_left_next == '0 && !pad_pending_next)
                               ? PH_CHUNK : PH_SKIP;
                end
                default: ;
            endcase
        end

        // saturate position
        if (pos_next != '1)
            pos_next = pos_next + 32'd1;

        if (s1_eof_reg)
        begin
            size_limit = wavhv_pkg::WAV_HEADER_BYTES + {1'b0, max_samples_reg, 1'b0};
            mismatch = !fmt_found_next || !data_found_next
                || format_code_next != wavhv_pkg::FORMAT_PCM
                || channels_next != expected_channels_reg
                || rate_seen_next != expected_rate_reg
                || sample_bits_next != expected_bits_reg
                || data_size_next == '0 || data_size_next[0]
                || data_size_next[31:1] > {7'b0, max_samples_reg};
            if (s1_len_reg == '0)
                status_next = wavhv_pkg::STATUS_EMPTY;
            else if (s1_len_reg > {6'b0, size_limit})
                status_next = wavhv_pkg::STATUS_TOO_LARGE;
            else if (fault_next || phase_next == PH_RIFF || pos_next < s1_len_reg)
                status_next = wavhv_pkg::STATUS_UNSUPPORTED;
            else if (mismatch)
                status_next = (data_size_next == '0) ? wavhv_pkg::STATUS_EMPTY
                                                     : wavhv_pkg::STATUS_UNSUPPORTED;
            else
                status_next = wavhv_pkg::STATUS_OK;
            accepted_next = (status_next == wavhv_pkg::STATUS_OK);

            // drop file state after the verdict
            phase_next        = PH_RIFF;
            pos_next          = '0;
            hdr_count_next    = '0;
            tag_shift_next    = '0;
            chunk_len_next    = '0;
            payload_left_next = '0;
            pad_pending_next  = 1'b0;
            format_code_next  = '0;
            channels_next     = '0;
            rate_seen_next    = '0;
            sample_bits_next  = '0;
            fmt_found_next    = 1'b0;
            data_found_next   = 1'b0;
            data_size_next    = '0;
            fault_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_samples_reg       <= wavhv_pkg::MAX_SAMPLES_RESET;
            expected_rate_reg     <= wavhv_pkg::EXPECTED_RATE_RESET;
            expected_channels_reg <= wavhv_pkg::EXPECTED_CHANNELS_RESET;
            expected_bits_reg     <= wavhv_pkg::EXPECTED_BITS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wavhv_pkg::CFG_MAX_SAMPLES:       max_samples_reg <= cfg_data[23:0];
                wavhv_pkg::CFG_EXPECTED_RATE:     expected_rate_reg <= cfg_data;
                wavhv_pkg::CFG_EXPECTED_CHANNELS: expected_channels_reg <= cfg_data[15:0];
                wavhv_pkg::CFG_EXPECTED_BITS:     expected_bits_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // hold the input beat until it is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_sof_reg  <= start_of_file;
            s1_eof_reg  <= end_of_file;
            s1_len_reg  <= file_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_RIFF;
            pos_reg          <= '0;
            hdr_count_reg    <= '0;
            tag_shift_reg    <= '0;
            chunk_len_reg    <= '0;
            payload_left_reg <= '0;
            pad_pending_reg  <= 1'b0;
            format_code_reg  <= '0;
            channels_reg     <= '0;
            rate_seen_reg    <= '0;
            sample_bits_reg  <= '0;
            fmt_found_reg    <= 1'b0;
            data_found_reg   <= 1'b0;
            data_size_reg    <= '0;
            fault_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            hdr_count_reg    <= hdr_count_next;
            tag_shift_reg    <= tag_shift_next;
            chunk_len_reg    <= chunk_len_next;
            payload_left_reg <= payload_left_next;
            pad_pending_reg  <= pad_pending_next;
            format_code_reg  <= format_code_next;
            channels_reg     <= channels_next;
            rate_seen_reg    <= rate_seen_next;
            sample_bits_reg  <= sample_bits_next;
            fmt_found_reg    <= fmt_found_next;
            data_found_reg   <= data_found_next;
            data_size_reg    <= data_size_next;
            fault_reg        <= fault_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            status_reg    <= wavhv_pkg::STATUS_OK;
        end
        else if (step && s1_eof_reg)
        begin
            out_valid_reg <= 1'b1;
            accepted_reg  <= accepted_next;
            status_reg    <= status_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ tb/wav_verdict_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_verdict_checker
// Watches the WAV header validator's ports, predicts each file verdict and
// compares it with the verdict the block returns.
// ----------------------------------------------------------------------------
// Mirrors the register writes and the accepted byte beats into a model of
// the RIFF/WAVE chunk walk. Each end_of_file beat queues one expected
// verdict. Each accepted output beat is compared field by field with the
// oldest queued verdict. Mismatches and unexpected beats are counted and
// handed to the testbench top, together with the number of verdicts still
// owed by the block.
module wav_verdict_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [wavhv_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [wavhv_pkg::CFG_WIDTH-1:0]         cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic [7:0]                              data_byte,
    input  logic                                    start_of_file,
    input  logic                                    end_of_file,
    input  logic [31:0]                             file_length,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic                                    accepted,
    input  logic [1:0]                              status,
    output int                                      fail_count,
    output int                                      verdicts_pending
);

    typedef enum logic [2:0] {
        WALK_PREAMBLE,
        WALK_HEADER,
        WALK_FMT,
        WALK_SKIP,
        WALK_DONE
    } walk_t;

    logic [23:0] lim_samples;
    logic [31:0] want_rate;
    logic [15:0] want_channels;
    logic [15:0] want_bits;

    logic [31:0] pos;
    walk_t       walk;
    logic [3:0]  hdr_idx;
    logic [31:0] tag_sr;
    logic [31:0] chunk_len;
    logic [32:0] skip_left;
    logic        pad_due;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] depth;
    logic        have_fmt;
    logic        have_data;
    logic [31:0] data_len;
    logic        fault_seen;

    wavhv_pkg::status_t expected_verdicts[$];
    int          fails = 0;

    function automatic void clear_file_state();
        pos        = '0;
        walk       = WALK_PREAMBLE;
        hdr_idx    = '0;
        tag_sr     = '0;
        chunk_len  = '0;
        skip_left  = '0;
        pad_due    = 1'b0;
        fmt_code   = '0;
        chans      = '0;
        rate       = '0;
        depth      = '0;
        have_fmt   = 1'b0;
        have_data  = 1'b0;
        data_len   = '0;
        fault_seen = 1'b0;
    endfunction

    function automatic void settle_skip();
        walk = (skip_left == '0 && !pad_due) ? WALK_HEADER : WALK_SKIP;
    endfunction

    // walk one file byte and queue a verdict on the last one
    function automatic void predict_byte(input logic [7:0] b, input logic sof,
                                         input logic eof, input logic [31:0] fl);
        logic [34:0] chunk_end;
        logic        is_fmt;
        logic [32:0] size_limit;
        wavhv_pkg::status_t v;
        if (sof)
            clear_file_state();
        if (pos < fl) begin
            case (walk)
                WALK_PREAMBLE: begin
                    tag_sr = {b, tag_sr[31:8]};
                    if ((hdr_idx == wavhv_pkg::PREAMBLE_TAG_LAST
                            && tag_sr != wavhv_pkg::TAG_RIFF) ||
                        (hdr_idx == wavhv_pkg::PREAMBLE_LAST
                            && tag_sr != wavhv_pkg::TAG_WAVE)) begin
                        fault_seen = 1'b1;
                        walk = WALK_DONE;
                    end else if (hdr_idx == wavhv_pkg::PREAMBLE_LAST) begin
                        hdr_idx = '0;
                        walk = WALK_HEADER;
                    end else begin
                        hdr_idx = hdr_idx + 4'd1;
                    end
                end
                WALK_HEADER: begin
                    if (hdr_idx == '0 && {3'b000, pos} + 35'd8 > {3'b000, fl}) begin
                        walk = WALK_DONE;
                    end else begin
                        if (hdr_idx <= wavhv_pkg::CHUNK_TAG_LAST)
                            tag_sr = {b, tag_sr[31:8]};
                        else
                            chunk_len = {b, chunk_len[31:8]};
                        if (hdr_idx < wavhv_pkg::CHUNK_HDR_LAST) begin
                            hdr_idx = hdr_idx + 4'd1;
                        end else begin
                            hdr_idx = '0;
                            chunk_end = {3'b000, pos} + 35'd1 + {3'b000, chunk_len};
                            is_fmt = (tag_sr == wavhv_pkg::TAG_FMT);
                            if (chunk_end + {34'd0, chunk_len[0]} > {3'b000, fl} ||
                                (is_fmt && chunk_len < wavhv_pkg::FMT_MIN_BYTES)) begin
                                fault_seen = 1'b1;
                                walk = WALK_DONE;
                            end else if (is_fmt) begin
                                walk = WALK_FMT;
                            end else begin
                                if (tag_sr == wavhv_pkg::TAG_DATA) begin
                                    have_data = 1'b1;
                                    data_len = chunk_len;
                                end
                                skip_left = {1'b0, chunk_len};
                                pad_due = chunk_len[0];
                                settle_skip();
                            end
                        end
                    end
                end
                WALK_FMT: begin
                    case (hdr_idx)
                        4'd0:  fmt_code = {8'h00, b};
                        4'd1:  fmt_code[15:8] = b;
                        4'd2:  chans = {8'h00, b};
                        4'd3:  chans[15:8] = b;
                        4'd4:  rate = {24'h000000, b};
                        4'd5:  rate[15:8] = b;
                        4'd6:  rate[23:16] = b;
                        4'd7:  rate[31:24] = b;
                        4'd14: depth = {8'h00, b};
                        4'd15: depth[15:8] = b;
                        default: ;
                    endcase
                    if (hdr_idx < wavhv_pkg::FMT_FIELDS_LAST) begin
                        hdr_idx = hdr_idx + 4'd1;
                    end else begin
                        hdr_idx = '0;
                        have_fmt = 1'b1;
                        skip_left = {1'b0, chunk_len} - {1'b0, wavhv_pkg::FMT_MIN_BYTES};
                        pad_due = chunk_len[0];
                        settle_skip();
                    end
                end
                WALK_SKIP: begin
                    if (skip_left != '0)
                        skip_left = skip_left - 33'd1;
                    else
                        pad_due = 1'b0;
                    settle_skip();
                end
                default: ;
            endcase
        end
        if (pos != 32'hFFFF_FFFF)
            pos = pos + 32'd1;
        if (eof) begin
            size_limit = {7'd0, wavhv_pkg::WAV_HEADER_BYTES} + {8'd0, lim_samples, 1'b0};
            if (fl == '0)
                v = wavhv_pkg::STATUS_EMPTY;
            else if ({1'b0, fl} > size_limit)
                v = wavhv_pkg::STATUS_TOO_LARGE;
            else if (fault_seen || walk == WALK_PREAMBLE || pos < fl)
                v = wavhv_pkg::STATUS_UNSUPPORTED;
            else if (!have_fmt || !have_data || fmt_code != wavhv_pkg::FORMAT_PCM ||
                     chans != want_channels || rate != want_rate ||
                     depth != want_bits || data_len == '0 || data_len[0] ||
                     data_len[31:1] > {7'd0, lim_samples})
                v = (data_len == '0) ? wavhv_pkg::STATUS_EMPTY
                                     : wavhv_pkg::STATUS_UNSUPPORTED;
            else
                v = wavhv_pkg::STATUS_OK;
            expected_verdicts.push_back(v);
            clear_file_state();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wavhv_pkg::status_t exp_v;
        if (!rst_n)
        begin
            lim_samples   = wavhv_pkg::MAX_SAMPLES_RESET;
            want_rate     = wavhv_pkg::EXPECTED_RATE_RESET;
            want_channels = wavhv_pkg::EXPECTED_CHANNELS_RESET;
            want_bits     = wavhv_pkg::EXPECTED_BITS_RESET;
            clear_file_state();
            expected_verdicts.delete();
        end
        else
        begin
            // compare before queuing, so a verdict never meets its own byte
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("verdict with none expected: accepted %0d status %0d",
                           accepted, status);
                    fails++;
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    if (accepted !== (exp_v == wavhv_pkg::STATUS_OK))
                    begin
                        $error("accepted: expected %0d, actual %0d",
                               exp_v == wavhv_pkg::STATUS_OK, accepted);
                        fails++;
                    end
                    if (status !== exp_v)
                    begin
                        $error("status: expected %0d, actual %0d", exp_v, status);
                        fails++;
                    end
                end
            end
            if (cfg_write === 1'b1)
            begin
                case (cfg_index)
                    wavhv_pkg::CFG_MAX_SAMPLES:       lim_samples   = cfg_data[23:0];
                    wavhv_pkg::CFG_EXPECTED_RATE:     want_rate     = cfg_data[31:0];
                    wavhv_pkg::CFG_EXPECTED_CHANNELS: want_channels = cfg_data[15:0];
                    wavhv_pkg::CFG_EXPECTED_BITS:     want_bits     = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                predict_byte(data_byte, start_of_file, end_of_file, file_length);
        end
        verdicts_pending <= expected_verdicts.size();
        fail_count <= fails;
    end

endmodule

@@ tb/tb_wav_header_validator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_header_validator
// Stimulus and verdict for the WAV header validator.
// ----------------------------------------------------------------------------
// Streams WAV files byte by byte into the block: a short directed set of
// empty, oversized, truncated and overrun files, then randomly built files,
// mostly well formed with random content and some broken on purpose, plus
// short noise files. The run walks through several register settings,
// extremes included, and three idling mixes on both channels, with one long
// output hold-off that backs the block up. The checker beside the block
// predicts and compares every verdict.
module tb_wav_header_validator;

    localparam int RUN_LIMIT   = 200000;
    localparam int HOLD_CYCLES = 48;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   cfg_write;
    logic [wavhv_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index;
    logic [wavhv_pkg::CFG_WIDTH-1:0]        cfg_data;
    logic                                   in_valid;
    logic                                   in_stall;
    logic [7:0]                             data_byte;
    logic                                   start_of_file;
    logic                                   end_of_file;
    logic [31:0]                            file_length;
    logic                                   out_valid;
    logic                                   out_stall;
    logic                                   accepted;
    logic [1:0]                             status;
    int                                     fail_count;
    int                                     verdicts_pending;

    int                                     cycle_count = 0;
    int                                     send_idle_pct = 0;
    int                                     recv_idle_pct = 0;
    logic                                   hold_req = 1'b0;

    logic [7:0]                             file_q[$];
    logic [31:0]                            file_len;
    logic                                   no_sof;
    int                                     glitch_at;
    logic [31:0]                            glitch_fl;
    int                                     fmt_len_at;
    int                                     data_len_at;

    logic [31:0]                            cur_rate;
    logic [15:0]                            cur_ch;
    logic [15:0]                            cur_bits;

    wav_header_validator u_dut (.*);

    wav_verdict_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb_wav_header_validator NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic sof, input logic eof,
                             input logic [31:0] fl);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_of_file <= sof;
        end_of_file   <= eof;
        file_length   <= fl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // hold the input until every verdict is back, then let the pipe settle
    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic [23:0] ms, input logic [31:0] rt,
                                input logic [15:0] ch, input logic [15:0] bt);
        logic [31:0] r;
        r = $urandom;
        cfg_write <= 1'b1;
        cfg_index <= wavhv_pkg::CFG_MAX_SAMPLES;
        cfg_data  <= {r[31:24], ms};
        @(posedge clk);
        cfg_index <= wavhv_pkg::CFG_EXPECTED_RATE;
        cfg_data  <= rt;
        @(posedge clk);
        cfg_index <= wavhv_pkg::CFG_EXPECTED_CHANNELS;
        cfg_data  <= {r[15:0], ch};
        @(posedge clk);
        cfg_index <= wavhv_pkg::CFG_EXPECTED_BITS;
        cfg_data  <= {r[23:8], bt};
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_rate = rt;
        cur_ch   = ch;
        cur_bits = bt;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_q.push_back(w[8*i +: 8]);
    endtask

    task automatic add_chunk(input logic [31:0] tag, input int len);
        push_word(tag);
        if (tag == wavhv_pkg::TAG_DATA)
            data_len_at = file_q.size();
        push_word(len);
        repeat (len) file_q.push_back(rand_byte());
        if (len % 2 == 1)
            file_q.push_back(rand_byte());
    endtask

    task automatic add_fmt();
        int          flen;
        logic [15:0] code;
        logic [15:0] ch;
        logic [31:0] rt;
        logic [15:0] bt;
        logic [31:0] r;
        flen = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20) : 16;
        code = wavhv_pkg::FORMAT_PCM;
        ch   = cur_ch;
        rt   = cur_rate;
        bt   = cur_bits;
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 3))
                0: code = code ^ (16'h0001 << $urandom_range(0, 15));
                1: ch   = ch ^ (16'h0001 << $urandom_range(0, 15));
                2: rt   = rt ^ (32'h0000_0001 << $urandom_range(0, 31));
                default: bt = bt ^ (16'h0001 << $urandom_range(0, 15));
            endcase
        end
        r = $urandom;
        push_word(wavhv_pkg::TAG_FMT);
        fmt_len_at = file_q.size();
        push_word(flen);
        push_word({ch, code});
        push_word(rt);
        push_word($urandom);
        push_word({bt, r[15:0]});
        repeat (flen - 16) file_q.push_back(rand_byte());
        if (flen % 2 == 1)
            file_q.push_back(rand_byte());
    endtask

    task automatic make_file();
        logic [31:0] riff_len;
        int          dlen;
        int          k;
        file_q.delete();
        no_sof      = 1'b0;
        glitch_at   = -1;
        glitch_fl   = '0;
        fmt_len_at  = -1;
        data_len_at = -1;
        if ($urandom_range(0, 99) < 35)
        begin
            // noise, sometimes behind a valid preamble
            if ($urandom_range(0, 1) == 1)
            begin
                push_word(wavhv_pkg::TAG_RIFF);
                push_word($urandom);
                push_word(wavhv_pkg::TAG_WAVE);
            end
            repeat ($urandom_range(1, 14)) file_q.push_back(rand_byte());
            case ($urandom_range(0, 2))
                0: file_len = file_q.size();
                1: file_len = $urandom_range(0, 24);
                default: file_len = $urandom;
            endcase
            no_sof = ($urandom_range(0, 4) == 0);
        end
        else
        begin
            push_word(wavhv_pkg::TAG_RIFF);
            push_word(32'd0);
            push_word(wavhv_pkg::TAG_WAVE);
            if ($urandom_range(0, 4) == 0)
                add_chunk($urandom, $urandom_range(0, 5));
            case ($urandom_range(0, 9))
                0: dlen = 0;
                1, 2: dlen = 2 * $urandom_range(0, 6) + 1;
                default: dlen = 2 * $urandom_range(1, 6);
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                add_chunk(wavhv_pkg::TAG_DATA, dlen);
                add_fmt();
            end
            else
            begin
                add_fmt();
                add_chunk(wavhv_pkg::TAG_DATA, dlen);
            end
            // a later chunk of the same kind overrides the earlier one
            case ($urandom_range(0, 9))
                0: add_chunk(wavhv_pkg::TAG_DATA, 2 * $urandom_range(0, 3));
                1: add_fmt();
                default: ;
            endcase
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 7)) file_q.push_back(rand_byte());
            riff_len = file_q.size() - 8;
            for (int i = 0; i < 4; i++)
                file_q[4 + i] = riff_len[8*i +: 8];
            file_len = file_q.size();
            if ($urandom_range(0, 99) < 30)
            begin
                case ($urandom_range(0, 9))
                    0: begin
                        k = $urandom_range(0, 11);
                        file_q[k] = file_q[k] ^ (8'h01 << $urandom_range(0, 7));
                    end
                    1: repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
                    2: repeat ($urandom_range(1, 4)) file_q.push_back(rand_byte());
                    3: file_len = file_len - $urandom_range(1, 12);
                    4: file_q[fmt_len_at] = rand_byte() & 8'h0F;
                    5: file_q[data_len_at + 3] = rand_byte() | 8'h01;
                    6: no_sof = 1'b1;
                    7: begin
                        glitch_at = $urandom_range(0, file_q.size() - 1);
                        glitch_fl = $urandom;
                    end
                    8: file_len = '0;
                    default: file_len = $urandom | 32'h8000_0000;
                endcase
            end
        end
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_beat(file_q[i], i == 0 && !no_sof, i == file_q.size() - 1,
                      (i == glitch_at) ? glitch_fl : file_len);
    endtask

    initial
    begin
        int phase_bytes;
        int phase_files;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = wavhv_pkg::CFG_MAX_SAMPLES;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_byte     = '0;
        start_of_file = 1'b0;
        end_of_file   = 1'b0;
        file_length   = '0;
        cur_rate      = wavhv_pkg::EXPECTED_RATE_RESET;
        cur_ch        = wavhv_pkg::EXPECTED_CHANNELS_RESET;
        cur_bits      = wavhv_pkg::EXPECTED_BITS_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty file and a length far past any limit
        send_beat(8'h00, 1'b1, 1'b1, 32'd0);
        send_beat(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // file ends inside the preamble
        send_beat(wavhv_pkg::TAG_RIFF[7:0], 1'b1, 1'b0, 32'd12);
        send_beat(wavhv_pkg::TAG_RIFF[15:8], 1'b0, 1'b0, 32'd12);
        send_beat(wavhv_pkg::TAG_RIFF[23:16], 1'b0, 1'b1, 32'd12);
        // no start mark
        send_beat(wavhv_pkg::TAG_RIFF[7:0], 1'b0, 1'b1, 32'd1);
        // bytes beyond the stated length
        for (int i = 0; i < 4; i++)
            send_beat(wavhv_pkg::TAG_RIFF[8*i +: 8], i == 0, i == 3, 32'd2);
        // stream shorter than the stated length
        send_beat(8'hA5, 1'b1, 1'b0, 32'd100);
        send_beat(8'h5A, 1'b0, 1'b1, 32'd100);
        // bare preamble with nothing after it
        file_q.delete();
        push_word(wavhv_pkg::TAG_RIFF);
        push_word(32'd4);
        push_word(wavhv_pkg::TAG_WAVE);
        for (int i = 0; i < 12; i++)
            send_beat(file_q[i], i == 0, i == 11, 32'd12);
        wait_for_verdicts();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                1: apply_config(24'd1, 32'd0, 16'd0, 16'd0);
                2: apply_config(24'hFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
                3: apply_config(24'd8, 32'd44100, 16'd2, 16'd16);
                4: apply_config(24'($urandom_range(1, 40)), $urandom,
                                16'($urandom), 16'($urandom));
                5: apply_config(24'($urandom_range(1, 24'hFF_FFFF)),
                                wavhv_pkg::EXPECTED_RATE_RESET,
                                wavhv_pkg::EXPECTED_CHANNELS_RESET,
                                wavhv_pkg::EXPECTED_BITS_RESET);
                default: ;
            endcase
            if (p < 2)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 66;
            end
            else if (p < 4)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 5)
            begin
                // back the block up behind a held output
                hold_req = 1'b1;
                repeat (24) send_beat(rand_byte(), 1'b1, 1'b1, $urandom_range(0, 60));
            end
            phase_bytes = 0;
            phase_files = 0;
            while (phase_bytes < 160 || phase_files < 4)
            begin
                make_file();
                send_file();
                phase_bytes += file_q.size();
                phase_files++;
            end
            wait_for_verdicts();
        end

        if (fail_count == 0)
            $display("tb_wav_header_validator OK");
        else
            $display("tb_wav_header_validator NOT OK");
        $finish;
    end

endmodule
